// File: hw/rtl/rpn_pkg.sv
// rpn_pkg: token codes, error codes, field widths and controller states
// for the RPN stack evaluator. No dependencies.
package rpn_pkg;

    localparam int FUNC_W = 4;
    localparam int NUM_W  = 31;
    localparam int DATA_W = 32;
    localparam int ERR_W  = 3;

    // Stream packing (byte-aligned tdata widths)
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Token codes (func field)
    localparam logic [FUNC_W-1:0] FN_PUSH     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_ADD      = 4'd1;
    localparam logic [FUNC_W-1:0] FN_SUB      = 4'd2;
    localparam logic [FUNC_W-1:0] FN_MUL      = 4'd3;
    localparam logic [FUNC_W-1:0] FN_DIV      = 4'd4;
    localparam logic [FUNC_W-1:0] FN_POST_INC = 4'd5;
    localparam logic [FUNC_W-1:0] FN_POST_DEC = 4'd6;
    localparam logic [FUNC_W-1:0] FN_PRE_INC  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_PRE_DEC  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_INDEX    = 4'd9;
    localparam logic [FUNC_W-1:0] FN_UNKNOWN  = 4'd10;
    localparam logic [FUNC_W-1:0] FN_END      = 4'd11;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_MISSING  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LEFTOVER = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;
    localparam logic [ERR_W-1:0] ERR_DIVZERO  = 3'd5;

    localparam int DIV_CNT_W = 5;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

// File: hw/rtl/rpn_stack_evaluator.sv
// rpn_stack_evaluator: reverse Polish integer evaluator, operand stack in
// a synchronous RAM, bit-serial divider. Depends on rpn_pkg.
//
// Usage: each input beat carries one token (func in s_tuser, literal in
// s_tdata) and produces exactly one output beat. Path per token: add,
// sub, push, inc/dec, index and error tokens go from the stack RAM read
// at the accept edge through the execute state and the result stage into
// the output register, which is loaded only once the previous beat is taken;
// mul adds a registered product stage; div adds the one-bit-per-cycle
// restoring divider. A new token is taken only after the previous result
// has moved into the output register, so one token is worked on at a time.
// The output register holds a result while the next token is already being
// worked on. The stack RAM has one write and two read ports (top and second
// entry) with registered reads; a stack write always lands in an earlier
// cycle than the next token's read, so no forwarding is needed. Stack
// contents are not cleared at reset or on end/error; only the count is, and
// entries at or above the count are never used. Sums, differences and
// products wrap; division truncates toward zero.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rpn_pkg::S_TDATA_W-1:0] s_tdata,   // [30:0] number, [31] zero
    input  logic [rpn_pkg::FUNC_W-1:0]    s_tuser,   // [3:0] func
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rpn_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] index_value,
                                                     // [34:32] error_code,
                                                     // [35] expr_ok, [39:36] zero
    output logic                          m_tuser,   // [0] index_valid
    output logic                          m_tlast    // expr_done
);
    import rpn_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PAD_W = M_TDATA_W - DATA_W - ERR_W - 1;

    // Stack RAM
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] top_rd_reg;
    logic [DATA_W-1:0] sec_rd_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // Control state
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              failed_reg, failed_next;
    logic [ERR_W-1:0]  first_err_reg, first_err_next;

    // Token latch
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [NUM_W-1:0]  num_reg, num_next;

    // Multiplier and divider
    logic [DATA_W-1:0]    prod_reg, prod_next;
    logic [DATA_W-1:0]    div_q_reg, div_q_next;
    logic [DATA_W-1:0]    div_r_reg, div_r_next;
    logic [DATA_W-1:0]    div_d_reg, div_d_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 div_neg_reg, div_neg_next;

    // Result staging
    logic              res_ivalid_reg, res_ivalid_next;
    logic [DATA_W-1:0] res_ivalue_reg, res_ivalue_next;
    logic [ERR_W-1:0]  res_err_reg, res_err_next;
    logic              res_done_reg, res_done_next;
    logic              res_ok_reg, res_ok_next;

    // Output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic              out_user_reg, out_user_next;
    logic              out_last_reg, out_last_next;

    // Address helpers
    logic [CW-1:0]     cnt_m1, cnt_m2;
    logic [AW-1:0]     top_addr, sec_addr;

    // Datapath helpers
    logic [DATA_W-1:0] lhs, rhs;
    logic [DATA_W-1:0] lhs_mag, rhs_mag;
    logic [DATA_W:0]   div_shift, div_diff;
    logic [DATA_W-1:0] div_q_step, div_r_step, div_quot;
    logic              has_one, has_two;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign top_addr = cnt_m1[AW-1:0];
    assign sec_addr = cnt_m2[AW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    assign lhs     = sec_rd_reg;
    assign rhs     = top_rd_reg;
    assign lhs_mag = lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
    assign rhs_mag = rhs[DATA_W-1] ? (DATA_W'(0) - rhs) : rhs;
    assign has_one = (count_reg >= CW'(1));
    assign has_two = (count_reg >= CW'(2));

    // One restoring step: shift next dividend bit into the remainder
    assign div_shift  = {div_r_reg, div_q_reg[DATA_W-1]};
    assign div_diff   = div_shift - {1'b0, div_d_reg};
    assign div_r_step = div_diff[DATA_W] ? div_shift[DATA_W-1:0] : div_diff[DATA_W-1:0];
    assign div_q_step = {div_q_reg[DATA_W-2:0], ~div_diff[DATA_W]};
    assign div_quot   = div_neg_reg ? (DATA_W'(0) - div_q_step) : div_q_step;

    // Stack RAM: registered reads of top and second entry every cycle
    always_ff @(posedge clk)
    begin
        top_rd_reg <= stack_mem[top_addr];
        sec_rd_reg <= stack_mem[sec_addr];
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        failed_next     = failed_reg;
        first_err_next  = first_err_reg;
        func_next       = func_reg;
        num_next        = num_reg;
        prod_next       = prod_reg;
        div_q_next      = div_q_reg;
        div_r_next      = div_r_reg;
        div_d_next      = div_d_reg;
        div_cnt_next    = div_cnt_reg;
        div_neg_next    = div_neg_reg;
        res_ivalid_next = res_ivalid_reg;
        res_ivalue_next = res_ivalue_reg;
        res_err_next    = res_err_reg;
        res_done_next   = res_done_reg;
        res_ok_next     = res_ok_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = top_addr;
        mem_wdata       = DATA_W'(0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    num_next   = s_tdata[NUM_W-1:0];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_ivalid_next = 1'b0;
                res_ivalue_next = DATA_W'(0);
                res_err_next    = ERR_NONE;
                res_done_next   = 1'b0;
                res_ok_next     = 1'b0;
                state_next      = ST_OUT;
                if (func_reg == FN_END)
                begin
                    res_done_next = 1'b1;
                    if (failed_reg)
                    begin
                        res_err_next = first_err_reg;
                    end
                    else if (count_reg != CW'(0))
                    begin
                        res_err_next = ERR_LEFTOVER;
                    end
                    else
                    begin
                        res_ok_next = 1'b1;
                    end
                    count_next     = CW'(0);
                    failed_next    = 1'b0;
                    first_err_next = ERR_NONE;
                end
                else if (!failed_reg)
                begin
                    unique case (func_reg)
                        FN_PUSH:
                        begin
                            if (count_reg >= CW'(STACK_DEPTH))
                            begin
                                res_err_next = ERR_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = {1'b0, num_reg};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                        begin
                            if (!has_two)
                            begin
                                res_err_next = ERR_MISSING;
                            end
                            else if (func_reg == FN_DIV && rhs == DATA_W'(0))
                            begin
                                res_err_next = ERR_DIVZERO;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                mem_waddr  = sec_addr;
                                if (func_reg == FN_ADD)
                                begin
                                    mem_we    = 1'b1;
                                    mem_wdata = lhs + rhs;
                                end
                                else if (func_reg == FN_SUB)
                                begin
                                    mem_we    = 1'b1;
                                    mem_wdata = lhs - rhs;
                                end
                                else if (func_reg == FN_MUL)
                                begin
                                    prod_next  = lhs * rhs;
                                    state_next = ST_MUL;
                                end
                                else
                                begin
                                    div_q_next   = lhs_mag;
                                    div_r_next   = DATA_W'(0);
                                    div_d_next   = rhs_mag;
                                    div_cnt_next = DIV_CNT_W'(0);
                                    div_neg_next = lhs[DATA_W-1] ^ rhs[DATA_W-1];
                                    state_next   = ST_DIV;
                                end
                            end
                        end
                        FN_POST_INC, FN_POST_DEC, FN_PRE_INC, FN_PRE_DEC, FN_INDEX:
                        begin
                            if (!has_one)
                            begin
                                res_err_next = ERR_MISSING;
                            end
                            else if (func_reg == FN_INDEX)
                            begin
                                res_ivalid_next = 1'b1;
                                res_ivalue_next = rhs;
                                count_next      = cnt_m1;
                            end
                            else if (func_reg == FN_PRE_INC)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = rhs + DATA_W'(1);
                            end
                            else if (func_reg == FN_PRE_DEC)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = rhs - DATA_W'(1);
                            end
                            // post inc/dec: top value is left unchanged
                        end
                        default:
                        begin
                            res_err_next = ERR_UNKNOWN;
                        end
                    endcase
                    if (res_err_next != ERR_NONE)
                    begin
                        count_next     = CW'(0);
                        failed_next    = 1'b1;
                        first_err_next = res_err_next;
                        mem_we         = 1'b0;
                        state_next     = ST_OUT;
                    end
                end
            end

            ST_MUL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = top_addr;
                mem_wdata  = prod_reg;
                state_next = ST_OUT;
            end

            ST_DIV:
            begin
                div_q_next   = div_q_step;
                div_r_next   = div_r_step;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DATA_W - 1))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = top_addr;
                    mem_wdata  = div_quot;
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {PAD_W'(0), res_ok_reg, res_err_reg, res_ivalue_reg};
                    out_user_next = res_ivalid_reg;
                    out_last_next = res_done_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            first_err_reg <= ERR_NONE;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            failed_reg    <= failed_next;
            first_err_reg <= first_err_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        num_reg        <= num_next;
        prod_reg       <= prod_next;
        div_q_reg      <= div_q_next;
        div_r_reg      <= div_r_next;
        div_d_reg      <= div_d_next;
        div_cnt_reg    <= div_cnt_next;
        div_neg_reg    <= div_neg_next;
        res_ivalid_reg <= res_ivalid_next;
        res_ivalue_reg <= res_ivalue_next;
        res_err_reg    <= res_err_next;
        res_done_reg   <= res_done_next;
        res_ok_reg     <= res_ok_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
        out_last_reg   <= out_last_next;
    end

    // Stack count never exceeds the RAM depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // An error empties the stack and records a nonzero code
    a_failed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (count_reg == CW'(0) && first_err_reg != ERR_NONE))
        else $error("failed with nonempty stack or no error code");

    // An accepted token is executed in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("token not executed after accept");

    // A successful end beat carries no error code
    a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && m_tdata[DATA_W+ERR_W]) |->
            (m_tdata[DATA_W+ERR_W-1:DATA_W] == ERR_NONE))
        else $error("expr_ok with error code");

    // The divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_d_reg != DATA_W'(0)))
        else $error("divide by zero reached divider");

endmodule
